[src/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// shared constants and types for the process table scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int Depth = 32;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	localparam logic [3:0] OP_PUSH = 4'd0;
	localparam logic [3:0] OP_POP = 4'd1;
	localparam logic [3:0] OP_CUR = 4'd2;
	localparam logic [3:0] OP_GETWORK = 4'd3;
	localparam logic [3:0] OP_GETSHARE = 4'd4;
	localparam logic [3:0] OP_SUB = 4'd5;
	localparam logic [3:0] OP_SETSHARE = 4'd6;
	localparam logic [3:0] OP_GETSTATE = 4'd7;
	localparam logic [3:0] OP_DELETE = 4'd8;
	localparam logic [3:0] OP_SORTUP = 4'd9;
	localparam logic [3:0] OP_SORTDN = 4'd10;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_ZERORES = 3'd4;

	typedef struct packed {
		logic [4:0] id;
		logic signed [31:0] work;
		logic signed [31:0] share;
		logic [1:0] pstate;
	} entry_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] pid_out;
		logic signed [31:0] work_out;
		logic signed [31:0] share_out;
		logic [1:0] state_out;
		logic finished;
	} result_t;

	// memory port control between sequencer and table
	typedef struct packed {
		logic we;
		logic [IdxW-1:0] waddr;
		entry_t wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

endpackage

[src/process_table_scheduler.sv]
// ----------------------------------------------------------------------------
// process_table_scheduler
// process table with round-robin pick, lookups, compaction and sorting
// ----------------------------------------------------------------------------
// push needs no table read; pop and current read one entry; lookups, subtract and delete
// scan the table, delete then shifts later entries down; set shares divides unset ones;
// sorts are selection sorts. one request in flight; next is taken after the result is taken.
// reset clears count, cursor and control; table contents stay undefined.
module process_table_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // opcode, pid_in, work_amount, resolution
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // status, pid_out, work_out, share_out, state_out, finished
);

	localparam int IW = pts_pkg::IdxW;
	localparam int CW = pts_pkg::CntW;

	typedef enum logic [3:0] {
		IDLE, DEC, SCAN, SUB_WR, SHR_RD, SHR_DIV, DEL_RD, SRT_I, SRT_J, SRT_SW1, SRT_SW2,
		OUT
	} state_t;

	state_t state_q;
	logic [3:0]  op_q;
	logic [4:0]  pid_q;
	logic [30:0] amt_q;
	logic [15:0] res_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cur_q;
	logic          cur_valid_q;
	logic [CW-1:0] i_q, j_q, pick_q, hit_q;
	logic          hit_valid_q;
	logic          rd_pend_q;
	pts_pkg::entry_t best_q, ei_q;
	pts_pkg::result_t res_out_q;
	pts_pkg::mem_req_t req;
	pts_pkg::entry_t rdata;
	logic div_start, div_done;
	logic signed [31:0] div_quo;
	logic signed [32:0] left;
	logic better;

	pts_table u_table (.clk(clk), .req(req), .rdata(rdata));
	pts_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(rdata.work),
		.divisor(res_q), .done(div_done), .quotient(div_quo));

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT);
	assign m_tdata = {5'd0, res_out_q.finished, res_out_q.state_out, res_out_q.share_out,
		res_out_q.work_out, res_out_q.pid_out, res_out_q.status};
	assign left = 33'(rdata.work) - 33'(amt_q);
	assign better = (op_q == pts_pkg::OP_SORTDN) ? (rdata.work > best_q.work)
		: (rdata.work < best_q.work);

	always_comb begin
		req = '0;
		div_start = 1'b0;
		case (state_q)
			IDLE: begin
				req.waddr = count_q[IW-1:0];
				req.wdata.id = 5'(count_q);
				req.wdata.work = {1'b0, s_tdata[39:9]};
				req.wdata.share = -32'sd1;
				req.wdata.pstate = 2'd0;
				req.we = s_tvalid && s_tdata[3:0] == pts_pkg::OP_PUSH
					&& count_q != CW'(pts_pkg::Depth);
				req.raddr = '0;
			end
			DEC: req.raddr = (op_q == pts_pkg::OP_POP) ?
				((cur_valid_q && cur_q + 1'b1 < count_q) ? IW'(cur_q + 1'b1) : '0)
				: cur_q[IW-1:0];
			SCAN: req.raddr = i_q[IW-1:0];
			SUB_WR: begin
				req.raddr = hit_q[IW-1:0];
				req.waddr = hit_q[IW-1:0];
				req.wdata = rdata;
				req.wdata.work = (left < -33'sd2147483648) ? 32'h80000000 : left[31:0];
				req.we = rd_pend_q;
			end
			SHR_RD: req.raddr = i_q[IW-1:0];
			SHR_DIV: begin
				div_start = rd_pend_q && rdata.share == -32'sd1;
				req.waddr = i_q[IW-1:0];
				req.wdata = ei_q;
				req.wdata.share = div_quo;
				req.we = div_done;
			end
			DEL_RD: begin
				req.raddr = IW'(i_q + 1'b1);
				req.waddr = i_q[IW-1:0];
				req.wdata = rdata;
				req.we = rd_pend_q;
			end
			SRT_I: req.raddr = i_q[IW-1:0];
			SRT_J: req.raddr = j_q[IW-1:0];
			SRT_SW1: req.raddr = pick_q[IW-1:0];
			SRT_SW2: begin
				req.waddr = i_q[IW-1:0];
				req.wdata = best_q;
				req.we = 1'b1;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			cur_valid_q <= 1'b0;
			cur_q <= '0;
			rd_pend_q <= 1'b0;
			hit_valid_q <= 1'b0;
			i_q <= '0; j_q <= '0; pick_q <= '0; hit_q <= '0;
			op_q <= '0;
			pid_q <= '0;
			amt_q <= '0;
			res_q <= '0;
			best_q <= '0;
			ei_q <= '0;
			res_out_q <= '0;
		end else begin
			case (state_q)
				IDLE: if (s_tvalid) begin
					op_q <= s_tdata[3:0];
					pid_q <= s_tdata[8:4];
					amt_q <= s_tdata[39:9];
					res_q <= s_tdata[55:40];
					i_q <= '0;
					rd_pend_q <= 1'b0;
					hit_valid_q <= 1'b0;
					if (s_tdata[3:0] == pts_pkg::OP_PUSH) begin
						if (count_q == CW'(pts_pkg::Depth))
							res_out_q.status <= pts_pkg::ST_FULL;
						else
							count_q <= count_q + 1'b1;
						state_q <= OUT;
					end else if (s_tdata[3:0] > pts_pkg::OP_SORTDN) begin
						state_q <= OUT;
					end else if (count_q == '0) begin
						res_out_q.status <= pts_pkg::ST_EMPTY;
						state_q <= OUT;
					end else if (s_tdata[3:0] == pts_pkg::OP_SETSHARE && s_tdata[55:40] == '0) begin
						res_out_q.status <= pts_pkg::ST_ZERORES;
						state_q <= OUT;
					end else begin
						state_q <= DEC;
					end
				end
				DEC: begin
					case (op_q)
						pts_pkg::OP_POP: begin
							cur_q <= (cur_valid_q && cur_q + 1'b1 < count_q) ? cur_q + 1'b1 : '0;
							cur_valid_q <= 1'b1;
							rd_pend_q <= 1'b1;
							state_q <= SCAN;
						end
						pts_pkg::OP_CUR: begin
							if (!cur_valid_q || cur_q >= count_q) begin
								res_out_q.status <= pts_pkg::ST_EMPTY;
								state_q <= OUT;
							end else begin
								rd_pend_q <= 1'b1;
								state_q <= SCAN;
							end
						end
						pts_pkg::OP_SETSHARE: state_q <= SHR_RD;
						pts_pkg::OP_SORTUP, pts_pkg::OP_SORTDN: state_q <= SRT_I;
						default: state_q <= SCAN;
					endcase
				end
				SCAN: begin
					if (op_q == pts_pkg::OP_POP || op_q == pts_pkg::OP_CUR) begin
						res_out_q.pid_out <= rdata.id;
						state_q <= OUT;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
						i_q <= i_q + 1'b1;
					end else begin
						if (rdata.id == pid_q && !(op_q == pts_pkg::OP_DELETE && hit_valid_q)) begin
							hit_q <= i_q - 1'b1;
							hit_valid_q <= 1'b1;
							ei_q <= rdata;
						end
						if (i_q == count_q) begin
							rd_pend_q <= 1'b0;
							state_q <= SUB_WR;
						end else
							i_q <= i_q + 1'b1;
					end
				end
				SUB_WR: begin
					if (!hit_valid_q) begin
						res_out_q.status <= pts_pkg::ST_NOTFOUND;
						state_q <= OUT;
					end else begin
						case (op_q)
							pts_pkg::OP_GETWORK: begin
								res_out_q.work_out <= ei_q.work;
								state_q <= OUT;
							end
							pts_pkg::OP_GETSHARE: begin
								res_out_q.share_out <= (ei_q.work >= ei_q.share) ? ei_q.share
									: ei_q.work;
								state_q <= OUT;
							end
							pts_pkg::OP_GETSTATE: begin
								res_out_q.state_out <= ei_q.pstate;
								state_q <= OUT;
							end
							pts_pkg::OP_SUB: begin
								if (!rd_pend_q)
									rd_pend_q <= 1'b1;
								else begin
									res_out_q.work_out <= (left < -33'sd2147483648) ?
										32'h80000000 : left[31:0];
									res_out_q.finished <= (left <= 0);
									state_q <= OUT;
								end
							end
							default: begin
								i_q <= hit_q;
								rd_pend_q <= 1'b0;
								state_q <= DEL_RD;
							end
						endcase
					end
				end
				SHR_RD: begin
					rd_pend_q <= 1'b1;
					state_q <= SHR_DIV;
				end
				SHR_DIV: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						ei_q <= rdata;
						if (rdata.share != -32'sd1) begin
							if (i_q + 1'b1 == count_q) state_q <= OUT;
							else begin i_q <= i_q + 1'b1; state_q <= SHR_RD; end
						end
					end else if (div_done) begin
						if (i_q + 1'b1 == count_q) state_q <= OUT;
						else begin i_q <= i_q + 1'b1; state_q <= SHR_RD; end
					end
				end
				DEL_RD: begin
					if (i_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						cur_valid_q <= 1'b0;
						state_q <= OUT;
					end else if (!rd_pend_q)
						rd_pend_q <= 1'b1;
					else begin
						rd_pend_q <= 1'b0;
						i_q <= i_q + 1'b1;
					end
				end
				SRT_I: begin
					if (i_q == count_q) state_q <= OUT;
					else if (!rd_pend_q) rd_pend_q <= 1'b1;
					else begin
						ei_q <= rdata;
						best_q <= rdata;
						pick_q <= i_q;
						j_q <= i_q + 1'b1;
						rd_pend_q <= 1'b0;
						state_q <= SRT_J;
					end
				end
				SRT_J: begin
					if (!rd_pend_q) begin
						if (j_q >= count_q) begin
							if (pick_q != i_q) state_q <= SRT_SW1;
							else begin i_q <= i_q + 1'b1; state_q <= SRT_I; end
						end else
							rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (better) begin
							best_q <= rdata;
							pick_q <= j_q;
						end
						j_q <= j_q + 1'b1;
					end
				end
				SRT_SW1: state_q <= SRT_SW2;
				SRT_SW2: begin
					// swap in two writes: best entry goes to i first, then old entry i goes to pick
					if (pick_q < i_q) begin
						i_q <= pick_q + 1'b1;
						state_q <= SRT_I;
					end else begin
						best_q <= ei_q;
						i_q <= pick_q;
						pick_q <= i_q;
					end
				end
				OUT: if (m_tready) begin
					res_out_q <= '0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(pts_pkg::Depth)) else $error("count over depth");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
`endif

endmodule

[src/pts_div.sv]
// ----------------------------------------------------------------------------
// pts_div
// serial signed 32 by unsigned 16 divider, truncates toward zero
// ----------------------------------------------------------------------------
module pts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic [15:0]        divisor,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic [31:0] mag_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, mag_q[31]};
	assign diff = trial - {1'b0, dsr_q};
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31];
			mag_q <= dividend[31] ? 32'(-dividend) : 32'(dividend);
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[30:0], 1'b0};
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

[src/pts_table.sv]
// ----------------------------------------------------------------------------
// pts_table
// entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pts_table (
	input  logic              clk,
	input  pts_pkg::mem_req_t req,
	output pts_pkg::entry_t   rdata
);

	pts_pkg::entry_t mem [pts_pkg::Depth];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		rdata <= mem[req.raddr];
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stream-level check of the process table scheduler against a behavioral
// model of the table: pushes, round-robin pops, lookups, subtracts, share
// setting, compaction and both sorts, with random gaps and back-pressure
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class table_scoreboard;
		logic [4:0] ids[pts_pkg::Depth];
		logic signed [31:0] work[pts_pkg::Depth];
		logic signed [31:0] share[pts_pkg::Depth];
		logic [1:0] pst[pts_pkg::Depth];
		int count;
		int cursor;
		pts_pkg::result_t pending[$];
		int errors;
		int checked;

		function new();
			count = 0;
			cursor = -1;
			errors = 0;
			checked = 0;
		endfunction

		function int find_last(logic [4:0] pid);
			int hit;
			hit = -1;
			for (int i = 0; i < count; i++)
				if (ids[i] == pid)
					hit = i;
			return hit;
		endfunction

		function void swap_at(int a, int b);
			logic [4:0] t5;
			logic signed [31:0] t32;
			logic [1:0] t2;
			t5 = ids[a]; ids[a] = ids[b]; ids[b] = t5;
			t32 = work[a]; work[a] = work[b]; work[b] = t32;
			t32 = share[a]; share[a] = share[b]; share[b] = t32;
			t2 = pst[a]; pst[a] = pst[b]; pst[b] = t2;
		endfunction

		function void note_request(logic [3:0] op, logic [4:0] pid, logic [30:0] amt,
				logic [15:0] res);
			pts_pkg::result_t r;
			int idx;
			int pick;
			longint left;
			logic signed [31:0] best;
			bit better;
			r = '0;
			if (op >= pts_pkg::OP_POP && op <= pts_pkg::OP_SORTDN && count == 0) begin
				r.status = pts_pkg::ST_EMPTY;
			end else begin
				case (op)
					pts_pkg::OP_PUSH: begin
						if (count >= pts_pkg::Depth) begin
							r.status = pts_pkg::ST_FULL;
						end else begin
							ids[count] = count[4:0];
							work[count] = {1'b0, amt};
							share[count] = -1;
							pst[count] = 2'd0;
							count++;
						end
					end
					pts_pkg::OP_POP: begin
						cursor = (cursor + 1) % count;
						r.pid_out = ids[cursor];
					end
					pts_pkg::OP_CUR: begin
						if (cursor < 0 || cursor >= count)
							r.status = pts_pkg::ST_EMPTY;
						else
							r.pid_out = ids[cursor];
					end
					pts_pkg::OP_GETWORK, pts_pkg::OP_GETSHARE, pts_pkg::OP_SUB,
					pts_pkg::OP_GETSTATE: begin
						idx = find_last(pid);
						if (idx < 0) begin
							r.status = pts_pkg::ST_NOTFOUND;
						end else if (op == pts_pkg::OP_GETWORK) begin
							r.work_out = work[idx];
						end else if (op == pts_pkg::OP_GETSHARE) begin
							r.share_out = (work[idx] >= share[idx]) ? share[idx] : work[idx];
						end else if (op == pts_pkg::OP_SUB) begin
							left = longint'(work[idx]) - longint'(amt);
							if (left < -64'sd2147483648)
								left = -64'sd2147483648;
							work[idx] = left[31:0];
							r.work_out = work[idx];
							r.finished = (left <= 0);
						end else begin
							r.state_out = pst[idx];
						end
					end
					pts_pkg::OP_SETSHARE: begin
						if (res == 0) begin
							r.status = pts_pkg::ST_ZERORES;
						end else begin
							for (int i = 0; i < count; i++)
								if (share[i] == -1)
									share[i] = 32'(longint'(work[i]) / longint'(res));
						end
					end
					pts_pkg::OP_DELETE: begin
						idx = -1;
						for (int i = 0; i < count; i++)
							if (idx < 0 && ids[i] == pid)
								idx = i;
						if (idx < 0) begin
							r.status = pts_pkg::ST_NOTFOUND;
						end else begin
							for (int i = idx; i + 1 < count; i++) begin
								ids[i] = ids[i + 1];
								work[i] = work[i + 1];
								share[i] = share[i + 1];
								pst[i] = pst[i + 1];
							end
							count--;
							cursor = -1;
						end
					end
					pts_pkg::OP_SORTUP, pts_pkg::OP_SORTDN: begin
						for (int i = 0; i < count; i++) begin
							best = work[i];
							pick = i;
							for (int j = i + 1; j < count; j++) begin
								better = (op == pts_pkg::OP_SORTDN) ? (work[j] > best)
									: (work[j] < best);
								if (better) begin
									best = work[j];
									pick = j;
								end
							end
							if (pick != i)
								swap_at(i, pick);
						end
					end
					default: ;
				endcase
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [79:0] data);
			pts_pkg::result_t got;
			pts_pkg::result_t want;
			got = unpack(data);
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", data);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp st=%0d pid=%0d work=%0d share=%0d state=%0d ",
						"fin=%0b / act st=%0d pid=%0d work=%0d share=%0d state=%0d fin=%0b"},
						want.status, want.pid_out, want.work_out, want.share_out,
						want.state_out, want.finished, got.status, got.pid_out,
						got.work_out, got.share_out, got.state_out, got.finished);
			end
		endfunction

		// status, pid_out, work_out, share_out, state_out, finished from bit 0 up
		function pts_pkg::result_t unpack(logic [79:0] d);
			pts_pkg::result_t r;
			r.status = d[2:0];
			r.pid_out = d[7:3];
			r.work_out = d[39:8];
			r.share_out = d[71:40];
			r.state_out = d[73:72];
			r.finished = d[74];
			return r;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;

	table_scoreboard sb;
	bit quiet;
	bit hold_off;
	int sent;

	process_table_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("tb_top failed");
		$finish;
	end

	task automatic send_request(logic [3:0] op, logic [4:0] pid, logic [30:0] amt,
			logic [15:0] res);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, res, amt, pid, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, pid, amt, res);
		sent++;
	endtask

	function automatic logic [30:0] rand_work();
		case ($urandom_range(0, 4))
			0: return 31'h7fffffff;
			1: return 31'd0;
			2: return 31'($urandom_range(0, 20));
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic random_request();
		logic [3:0] op;
		int k;
		k = $urandom_range(0, 99);
		if (k < 22) op = pts_pkg::OP_PUSH;
		else if (k < 32) op = pts_pkg::OP_POP;
		else if (k < 37) op = pts_pkg::OP_CUR;
		else if (k < 47) op = pts_pkg::OP_GETWORK;
		else if (k < 55) op = pts_pkg::OP_GETSHARE;
		else if (k < 67) op = pts_pkg::OP_SUB;
		else if (k < 72) op = pts_pkg::OP_SETSHARE;
		else if (k < 77) op = pts_pkg::OP_GETSTATE;
		else if (k < 87) op = pts_pkg::OP_DELETE;
		else if (k < 91) op = pts_pkg::OP_SORTUP;
		else if (k < 95) op = pts_pkg::OP_SORTDN;
		else op = 4'($urandom_range(11, 15));
		send_request(op, 5'($urandom_range(0, 31)), rand_work(),
			($urandom_range(0, 7) == 0) ? 16'd0 :
			($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(1, 65535)));
	endtask

	// sink side: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 14);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	initial begin
		int waited;
		sb = new();
		quiet = 0;
		hold_off = 0;
		sent = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, fill, full, share and state lookups, subtracts and every error
		send_request(pts_pkg::OP_POP, 0, 0, 1);
		send_request(pts_pkg::OP_CUR, 0, 0, 1);
		send_request(pts_pkg::OP_SORTUP, 0, 0, 1);
		send_request(pts_pkg::OP_PUSH, 0, 31'h7fffffff, 0);
		send_request(pts_pkg::OP_CUR, 0, 0, 1);
		send_request(pts_pkg::OP_GETSHARE, 0, 0, 0);
		send_request(pts_pkg::OP_SUB, 0, 31'h7fffffff, 0);
		send_request(pts_pkg::OP_SUB, 0, 31'h7fffffff, 0);
		send_request(pts_pkg::OP_SUB, 0, 31'h7fffffff, 0);
		send_request(pts_pkg::OP_GETSHARE, 0, 0, 0);
		send_request(pts_pkg::OP_PUSH, 0, 31'd7, 0);
		send_request(pts_pkg::OP_SETSHARE, 0, 0, 16'd0);
		send_request(pts_pkg::OP_SETSHARE, 0, 0, 16'hffff);
		send_request(pts_pkg::OP_GETSHARE, 1, 0, 0);
		send_request(pts_pkg::OP_GETSTATE, 31, 0, 0);
		send_request(pts_pkg::OP_GETSTATE, 1, 0, 0);
		send_request(4'd15, 0, 0, 0);
		for (int i = 0; i < 31; i++)
			send_request(pts_pkg::OP_PUSH, 0, 31'($urandom()), 0);
		send_request(pts_pkg::OP_SORTDN, 0, 0, 1);
		send_request(pts_pkg::OP_SORTUP, 0, 0, 1);
		send_request(pts_pkg::OP_POP, 0, 0, 1);
		send_request(pts_pkg::OP_DELETE, 5, 0, 1);
		send_request(pts_pkg::OP_CUR, 0, 0, 1);

		// random part, with a long sink stall early on
		hold_off = 1;
		for (int n = 0; n < 1300; n++) begin
			if (n == 1150)
				quiet = 1;
			random_request();
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		$display("sent %0d requests, checked %0d results covering all opcodes,",
			sent, sb.checked);
		$display("full/empty/not-found/zero-divisor cases and sink back-pressure");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d errors, %0d results missing", sb.errors, sb.pending.size());
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[process_table_scheduler.f]
src/pts_pkg.sv
src/pts_div.sv
src/pts_table.sv
src/process_table_scheduler.sv
bench/tb_top.sv
